// ===== sv/itr_pkg.sv =====
// shared constants, state type and digit-to-ascii helper for the radix text converter
package itr_pkg;

    localparam int DEFAULT_VALUE_BITS = 32;
    localparam int RADIX_W = 6;
    localparam int CHAR_W = 8;
    // quotient bits produced per cycle of the shared divide step
    localparam int DIV_STEPS = 8;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] DECIMAL = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_RD,
        ST_LD
    } state_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DECIMAL)
        begin
            c = CHAR_ZERO + {2'b00, d};
        end
        else
        begin
            c = CHAR_A + {2'b00, d - DECIMAL};
        end
        return c;
    endfunction

endpackage

// ===== sv/itr_in_if.sv =====
// input channel: value and signed/unsigned kind with valid/ready
interface itr_in_if #(
    parameter int VALUE_BITS = itr_pkg::DEFAULT_VALUE_BITS
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    logic                  kind;

    modport source (output valid, output value, output kind, input ready);
    modport sink (input valid, input value, input kind, output ready);
endinterface

// ===== sv/itr_out_if.sv =====
// output channel: one ascii character per beat with last marker
interface itr_out_if;
    logic                        valid;
    logic                        ready;
    logic [itr_pkg::CHAR_W-1:0]  char_code;
    logic                        last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink (input valid, input char_code, input last, output ready);
endinterface

// ===== sv/integer_to_radix_text.sv =====
// integer to ascii text converter in a configurable radix using a shared divide step
//
//  channel   dir   beat contents
//  in_ch     in    value, kind (0 unsigned, 1 signed)
//  out_ch    out   char_code, last
//  radix_wr  in    radix_wr_en, radix_wr_data (6 bits)
//
// each digit comes from the shared divide step, run until all VALUE_BITS are shifted through;
// then each character is read back through the digit store read port, the minus sign first
// in_ch.ready is high only in idle; the last character may still wait in the output register
// a stalled output holds the sequencer; reset returns to idle with radix 10
module integer_to_radix_text #(
    parameter int VALUE_BITS = itr_pkg::DEFAULT_VALUE_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         radix_wr_en,
    input  logic [itr_pkg::RADIX_W-1:0]  radix_wr_data,
    itr_in_if.sink                       in_ch,
    itr_out_if.source                    out_ch
);

    localparam int CYC = (VALUE_BITS + itr_pkg::DIV_STEPS - 1) / itr_pkg::DIV_STEPS;
    localparam int PAD = CYC * itr_pkg::DIV_STEPS;
    localparam int STEP_W = (CYC > 1) ? $clog2(CYC) : 1;
    localparam int CNT_W = $clog2(VALUE_BITS + 1);
    localparam int AW = $clog2(VALUE_BITS);
    localparam int RW = itr_pkg::RADIX_W;

    itr_pkg::state_t state_reg, state_next;

    logic [RW-1:0]             radix_reg;
    logic [RW-1:0]             eff_radix;
    logic [PAD-1:0]            div_reg, div_next;
    logic [RW-1:0]             rem_reg, rem_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          idx_reg, idx_next;
    logic [CNT_W-1:0]          idx_m1;
    logic                      neg_reg, neg_next;
    logic                      out_valid_reg, out_valid_next;
    logic [itr_pkg::CHAR_W-1:0] char_reg, char_next;
    logic                      last_reg, last_next;
    logic                      out_free;
    logic                      accept;
    logic                      neg_in;
    logic [VALUE_BITS-1:0]     mag_in;

    logic [RW-1:0]             store [VALUE_BITS];
    logic [RW-1:0]             rd_data_reg;
    logic                      store_we;
    logic [AW-1:0]             store_waddr;
    logic [RW-1:0]             store_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= itr_pkg::RADIX_RESET;
        end
        else if (radix_wr_en)
        begin
            radix_reg <= radix_wr_data;
        end
    end

    // registers 0,1 act as 2 and anything above 36 acts as 36
    always_comb
    begin
        if (radix_reg < itr_pkg::RADIX_MIN)
        begin
            eff_radix = itr_pkg::RADIX_MIN;
        end
        else if (radix_reg > itr_pkg::RADIX_MAX)
        begin
            eff_radix = itr_pkg::RADIX_MAX;
        end
        else
        begin
            eff_radix = radix_reg;
        end
    end

    assign accept = in_ch.valid && in_ch.ready;
    assign neg_in = in_ch.kind && (eff_radix == itr_pkg::DECIMAL) && in_ch.value[VALUE_BITS-1];
    // most negative value negates to itself, which is the right magnitude
    assign mag_in = neg_in ? (~in_ch.value + 1'b1) : in_ch.value;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign idx_m1 = idx_reg - 1'b1;

    assign in_ch.ready = (state_reg == itr_pkg::ST_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.char_code = char_reg;
    assign out_ch.last = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= itr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        logic [RW:0]    r;
        logic [PAD-1:0] d;
        logic           qb;

        state_next = state_reg;
        div_next = div_reg;
        rem_next = rem_reg;
        step_next = step_reg;
        count_next = count_reg;
        idx_next = idx_reg;
        neg_next = neg_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        char_next = char_reg;
        last_next = last_reg;
        store_we = 1'b0;
        store_waddr = count_reg[AW-1:0];

        // restoring divide by the radix, DIV_STEPS quotient bits shifted in per cycle
        r = {1'b0, rem_reg};
        d = div_reg;
        for (int i = 0; i < itr_pkg::DIV_STEPS; i++)
        begin
            r = {r[RW-1:0], d[PAD-1]};
            qb = (r >= {1'b0, eff_radix});
            if (qb)
            begin
                r = r - {1'b0, eff_radix};
            end
            d = {d[PAD-2:0], qb};
        end
        store_wdata = r[RW-1:0];

        unique case (state_reg)
            itr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    div_next = PAD'(mag_in);
                    rem_next = '0;
                    step_next = '0;
                    count_next = '0;
                    neg_next = neg_in;
                    state_next = itr_pkg::ST_DIV;
                end
            end
            itr_pkg::ST_DIV:
            begin
                div_next = d;
                if (step_reg == STEP_W'(CYC - 1))
                begin
                    store_we = 1'b1;
                    count_next = count_reg + 1'b1;
                    rem_next = '0;
                    step_next = '0;
                    if (d == '0 || (count_reg + 1'b1) == CNT_W'(VALUE_BITS))
                    begin
                        idx_next = count_reg + 1'b1;
                        state_next = neg_reg ? itr_pkg::ST_SIGN : itr_pkg::ST_RD;
                    end
                end
                else
                begin
                    rem_next = r[RW-1:0];
                    step_next = step_reg + 1'b1;
                end
            end
            itr_pkg::ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next = itr_pkg::CHAR_MINUS;
                    last_next = 1'b0;
                    state_next = itr_pkg::ST_RD;
                end
            end
            itr_pkg::ST_RD:
            begin
                // wait state while the store read for the current index is registered into rd_data_reg
                state_next = itr_pkg::ST_LD;
            end
            itr_pkg::ST_LD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next = itr_pkg::digit_char(rd_data_reg);
                    last_next = (idx_reg == CNT_W'(1));
                    idx_next = idx_m1;
                    state_next = (idx_reg == CNT_W'(1)) ? itr_pkg::ST_IDLE : itr_pkg::ST_RD;
                end
            end
            default:
            begin
                state_next = itr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg <= '0;
            idx_reg <= '0;
            step_reg <= '0;
            neg_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            count_reg <= count_next;
            idx_reg <= idx_next;
            step_reg <= step_next;
            neg_reg <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        rem_reg <= rem_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    // digit store, least significant digit first, read back in reverse
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store[store_waddr] <= store_wdata;
        end
        rd_data_reg <= store[idx_m1[AW-1:0]];
    end

`ifndef NO_ASSERTIONS
    a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == itr_pkg::ST_DIV)
        else $error("accepted beat did not start the divide");

    a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == itr_pkg::ST_DIV |-> rem_reg < eff_radix)
        else $error("partial remainder not below radix");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(VALUE_BITS))
        else $error("digit count beyond store depth");

    a_idx_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == itr_pkg::ST_RD || state_reg == itr_pkg::ST_LD) |-> idx_reg != '0)
        else $error("reading digits with none left");

    a_last_not_minus: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.last |-> out_ch.char_code != itr_pkg::CHAR_MINUS)
        else $error("minus sign marked as last beat");
`endif

endmodule
